>>> hdl/pktb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pktb_pkg;

    localparam int KEY_COUNT  = 256;
    localparam int IDX_W      = $clog2(KEY_COUNT);

    localparam int ACTION_W   = 1;
    localparam int PATCH_W    = 8;
    localparam int STAMP_W    = 48;
    localparam int LEVEL_W    = 32;
    localparam int RATE_W     = 20;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // elapsed time is clamped to 2^32 ms, so it needs one bit more than a level
    localparam int DT_W       = 33;
    localparam int ALU_W      = 54;
    localparam int CNT_W      = $clog2(RATE_W);

    localparam logic [RATE_W-1:0]  RATE_RESET     = RATE_W'(2000);
    localparam logic [LEVEL_W-1:0] CAPACITY_RESET = LEVEL_W'(10000000);
    localparam logic [LEVEL_W-1:0] COST_RESET     = LEVEL_W'(1000000);

    localparam logic ACT_CONSUME = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFILL_RATE     = 2'd0,
        CFG_BUCKET_CAPACITY = 2'd1,
        CFG_TOKEN_COST      = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [LEVEL_W-1:0] level;
        logic [STAMP_W-1:0] stamp;
    } t_tbl_wr;

endpackage
`default_nettype wire

>>> hdl/pktb_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pktb_req_if;
    import pktb_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PATCH_W-1:0]  patch_index;
    logic [STAMP_W-1:0]  now_ms;

    modport source (output valid, action, patch_index, now_ms, input ready);
    modport sink   (input valid, action, patch_index, now_ms, output ready);
endinterface
`default_nettype wire

>>> hdl/pktb_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pktb_rsp_if;
    import pktb_pkg::*;

    logic               valid;
    logic               ready;
    logic               consumed;
    logic [LEVEL_W-1:0] tokens_left;

    modport source (output valid, consumed, tokens_left, input ready);
    modport sink   (input valid, consumed, tokens_left, output ready);
endinterface
`default_nettype wire

>>> hdl/pktb_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module pktb_alu (
    input  wire logic [pktb_pkg::ALU_W-1:0] i_a,
    input  wire logic [pktb_pkg::ALU_W-1:0] i_b,
    input  wire logic                       i_sub,
    output logic      [pktb_pkg::ALU_W-1:0] o_sum,
    output logic                            o_carry
);
    import pktb_pkg::*;

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   full;

    // subtract as a + ~b + 1; carry out set means a >= b
    assign b_eff   = i_sub ? ~i_b : i_b;
    assign full    = {1'b0, i_a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, i_sub};
    assign o_sum   = full[ALU_W-1:0];
    assign o_carry = full[ALU_W];
endmodule
`default_nettype wire

>>> hdl/pktb_table.sv
`timescale 1ns / 1ps
`default_nettype none
module pktb_table (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_rd_en,
    input  wire logic [pktb_pkg::IDX_W-1:0]     i_rd_idx,
    input  wire pktb_pkg::t_tbl_wr              i_wr,
    output logic      [pktb_pkg::LEVEL_W-1:0]   o_rd_level,
    output logic      [pktb_pkg::STAMP_W-1:0]   o_rd_stamp
);
    import pktb_pkg::*;

    logic [LEVEL_W-1:0] mem_level [KEY_COUNT];
    logic [STAMP_W-1:0] mem_stamp [KEY_COUNT];
    logic [KEY_COUNT-1:0] r_valid;
    logic               r_rd_valid;
    logic [LEVEL_W-1:0] r_rd_level;
    logic [STAMP_W-1:0] r_rd_stamp;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_level[i_wr.idx] <= i_wr.level;
            mem_stamp[i_wr.idx] <= i_wr.stamp;
        end
        if (i_rd_en) begin
            r_rd_level <= mem_level[i_rd_idx];
            r_rd_stamp <= mem_stamp[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    // an untouched key reads as a full bucket that was never seen
    assign o_rd_level = r_rd_valid ? r_rd_level : CAPACITY_RESET;
    assign o_rd_stamp = r_rd_valid ? r_rd_stamp : '0;
endmodule
`default_nettype wire

>>> hdl/per_key_token_bucket_limiter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-key token bucket limiter. Each request on i_req names a key (patch_index),
// a millisecond timestamp and an action (0 consume, 1 query); each request
// yields exactly one response on o_rsp with the consume flag and the bucket
// level in micro-tokens. A request to a key whose stored time is zero, or
// whose timestamp runs backwards, records its time without a refill. Otherwise
// the level grows by refill_rate * elapsed_ms (elapsed clamped to 2^32 ms) and
// is capped at bucket_capacity. In both cases a consume then takes token_cost
// if the level covers it. Timing: the block takes one request at a time. A
// refilling request runs the elapsed-time subtract against the registered
// table read, 20 shift-add steps for the rate multiply, add, cap compare, cost
// compare and write-back; a first-access or backwards request goes from the
// subtract straight to the cost compare. The next request can transfer as soon
// as the response shows. The single shared 54-bit adder/subtractor in pktb_alu
// does every arithmetic step. i_req.ready is high again once the write-back is
// done, even while the last response still waits on o_rsp. Keys start full
// after reset through per-entry valid bits, so no clearing pass is needed.
// Configuration writes on i_cfg_we/i_cfg_idx/i_cfg_data take effect at once;
// write them only while idle.
module per_key_token_bucket_limiter_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pktb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pktb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pktb_req_if.sink                               i_req,
    pktb_rsp_if.source                             o_rsp
);
    import pktb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DT,
        S_MUL,
        S_ADD,
        S_CAP,
        S_COST,
        S_WB
    } t_state;

    t_state              r_state;
    logic [RATE_W-1:0]   r_rate;
    logic [LEVEL_W-1:0]  r_capacity;
    logic [LEVEL_W-1:0]  r_cost;

    logic                r_action;
    logic [IDX_W-1:0]    r_idx;
    logic [STAMP_W-1:0]  r_now;
    logic [LEVEL_W-1:0]  r_level;
    logic [DT_W-1:0]     r_dt;
    logic [ALU_W-1:0]    r_acc;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_took;

    logic                r_out_valid;
    logic                r_out_consumed;
    logic [LEVEL_W-1:0]  r_out_tokens;

    logic                req_xfer;
    logic                wb_go;
    logic [LEVEL_W-1:0]  rd_level;
    logic [STAMP_W-1:0]  rd_stamp;
    t_tbl_wr             tbl_wr;

    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic                alu_sub;
    logic [ALU_W-1:0]    alu_sum;
    logic                alu_carry;
    logic [STAMP_W-1:0]  elapsed;
    logic                dt_over;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;

    // hold the write-back until the previous response has been taken
    assign wb_go = (r_state == S_WB) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.consumed    = r_out_consumed;
    assign o_rsp.tokens_left = r_out_tokens;

    assign tbl_wr.en    = wb_go;
    assign tbl_wr.idx   = r_idx;
    assign tbl_wr.level = r_level;
    assign tbl_wr.stamp = r_now;

    pktb_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (req_xfer),
        .i_rd_idx   (i_req.patch_index[IDX_W-1:0]),
        .i_wr       (tbl_wr),
        .o_rd_level (rd_level),
        .o_rd_stamp (rd_stamp)
    );

    // operand selection for the shared adder, one use per sequencer step
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_DT: begin
                alu_a   = ALU_W'(r_now);
                alu_b   = ALU_W'(rd_stamp);
                alu_sub = 1'b1;
            end
            S_MUL: begin
                alu_a = r_acc;
                alu_b = ALU_W'(r_dt) << r_cnt;
            end
            S_ADD: begin
                alu_a = ALU_W'(r_level);
                alu_b = r_acc;
            end
            S_CAP: begin
                alu_a   = r_acc;
                alu_b   = ALU_W'(r_capacity);
                alu_sub = 1'b1;
            end
            S_COST: begin
                alu_a   = ALU_W'(r_level);
                alu_b   = ALU_W'(r_cost);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    pktb_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    // clamp elapsed time to 2^32 ms; beyond that any nonzero rate fills the bucket
    assign elapsed = alu_sum[STAMP_W-1:0];
    assign dt_over = (|elapsed[STAMP_W-1:DT_W]) ||
                     (elapsed[DT_W-1] && (|elapsed[DT_W-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_capacity  <= CAPACITY_RESET;
            r_cost      <= COST_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_REFILL_RATE:     r_rate     <= i_cfg_data[RATE_W-1:0];
                    CFG_BUCKET_CAPACITY: r_capacity <= i_cfg_data[LEVEL_W-1:0];
                    CFG_TOKEN_COST:      r_cost     <= i_cfg_data[LEVEL_W-1:0];
                    default: begin
                        // unlisted index: drop the write
                    end
                endcase
            end

            // a new response loaded this cycle takes precedence over the drain
            if (o_rsp.valid && o_rsp.ready && !wb_go) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_xfer) begin
                        r_action <= i_req.action;
                        r_idx    <= i_req.patch_index[IDX_W-1:0];
                        r_now    <= i_req.now_ms;
                        r_state  <= S_DT;
                    end
                end
                S_DT: begin
                    r_level <= rd_level;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_dt    <= dt_over ? {1'b1, {(DT_W-1){1'b0}}} : elapsed[DT_W-1:0];
                    // first access or time running backwards: no refill, go straight to the cost check
                    if (rd_stamp == '0 || !alu_carry) begin
                        r_state <= S_COST;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_rate[r_cnt]) begin
                        r_acc <= alu_sum;
                    end
                    if (r_cnt == CNT_W'(RATE_W - 1)) begin
                        r_state <= S_ADD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ADD: begin
                    r_acc   <= alu_sum;
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_level <= alu_carry ? r_capacity : r_acc[LEVEL_W-1:0];
                    r_state <= S_COST;
                end
                S_COST: begin
                    r_took <= (r_action == ACT_CONSUME) && alu_carry;
                    if (r_action == ACT_CONSUME && alu_carry) begin
                        r_level <= alu_sum[LEVEL_W-1:0];
                    end
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (wb_go) begin
                        r_out_valid    <= 1'b1;
                        r_out_consumed <= r_took;
                        r_out_tokens   <= r_level;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
